/* rtl/sss_pkg.sv */
`default_nettype none
package sss_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int FUNC_W       = 3;
    localparam int VAL_W        = 32;
    localparam int IDX_W        = 4;
    localparam int POS_W        = 4;
    localparam int CNT_W        = 5;
    localparam int ERR_W        = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 3'd0,
        FUNC_REMOVE = 3'd1,
        FUNC_FIND   = 3'd2,
        FUNC_CLEAR  = 3'd3,
        FUNC_SORT   = 3'd4,
        FUNC_READ   = 3'd5
    } func_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        RD_AT_I     = 2'd0,
        RD_AT_NEXT  = 2'd1,
        RD_AT_INDEX = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    set_hit;
        logic    inc_i;
        logic    wr_add;
        logic    wr_shift;
        logic    dec_fill;
        logic    clr_fill;
        logic    ld_carry;
        logic    sort_step;
        logic    init_lim;
        logic    sort_end;
        logic    err_full;
        logic    err_range;
        logic    take_read;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              match;
        logic              hit;
        logic              more_entries;
        logic              fill_empty;
        logic              fill_gt1;
        logic              full;
        logic              idx_ok;
        logic              sort_more;
        logic              lim_gt1;
    } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/sss_ctrl.sv */
`default_nettype none
module sss_ctrl
    import sss_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd,
    output logic          busy
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DECODE   = 13'b0000000000010,
        S_SRCH_RD  = 13'b0000000000100,
        S_SRCH_CMP = 13'b0000000001000,
        S_EXEC     = 13'b0000000010000,
        S_SHIFT_RD = 13'b0000000100000,
        S_SHIFT_WR = 13'b0000001000000,
        S_READ_W   = 13'b0000010000000,
        S_SORT_LD  = 13'b0000100000000,
        S_SORT_LDW = 13'b0001000000000,
        S_SORT_RD  = 13'b0010000000000,
        S_SORT_CMP = 13'b0100000000000,
        S_SORT_END = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_AT_I;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.func == FUNC_ADD || stat.func == FUNC_REMOVE ||
                    stat.func == FUNC_FIND)
                begin
                    if (stat.fill_empty)
                    begin
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_AT_I;
                        state_next = S_SRCH_CMP;
                    end
                end
                else if (stat.func == FUNC_CLEAR)
                begin
                    cmd.clr_fill = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.func == FUNC_SORT)
                begin
                    if (stat.fill_gt1)
                    begin
                        cmd.init_lim = 1'b1;
                        state_next   = S_SORT_LD;
                    end
                    else
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.func == FUNC_READ)
                begin
                    if (stat.idx_ok)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_AT_INDEX;
                        state_next = S_READ_W;
                    end
                    else
                    begin
                        cmd.err_range = 1'b1;
                        cmd.finish    = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT_I;
                state_next = S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_hit = 1'b1;
                    state_next  = S_EXEC;
                end
                else if (stat.more_entries)
                begin
                    cmd.inc_i  = 1'b1;
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.func == FUNC_REMOVE && stat.hit)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    if (stat.func == FUNC_ADD && !stat.hit)
                    begin
                        if (stat.full)
                        begin
                            cmd.err_full = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_add = 1'b1;
                        end
                    end
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT_RD:
            begin
                if (stat.more_entries)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_AT_NEXT;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd.dec_fill = 1'b1;
                    cmd.finish   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.inc_i    = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_READ_W:
            begin
                cmd.take_read = 1'b1;
                cmd.finish    = 1'b1;
                state_next    = S_IDLE;
            end
            S_SORT_LD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT_I;
                state_next = S_SORT_LDW;
            end
            S_SORT_LDW:
            begin
                cmd.ld_carry = 1'b1;
                state_next   = S_SORT_RD;
            end
            S_SORT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AT_NEXT;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                cmd.sort_step = 1'b1;
                if (stat.sort_more)
                begin
                    state_next = S_SORT_RD;
                end
                else
                begin
                    state_next = S_SORT_END;
                end
            end
            S_SORT_END:
            begin
                cmd.sort_end = 1'b1;
                if (stat.lim_gt1)
                begin
                    state_next = S_SORT_LD;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/sss_datapath.sv */
`default_nettype none
module sss_datapath
    import sss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [FUNC_W-1:0]       func,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic [IDX_W-1:0]        index,
    input  wire dp_cmd_t                 cmd,
    output dp_stat_t                     stat,
    output logic                         done,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic [CNT_W-1:0]             count,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [ERR_W-1:0]             error
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam int PW = (AW > POS_W) ? AW : POS_W;
    localparam int NW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [VAL_W-1:0] entry_mem [CAPACITY];

    logic [FUNC_W-1:0]       func_reg;
    logic [VAL_W-1:0]        value_reg;
    logic [IDX_W-1:0]        index_reg;
    logic [CW-1:0]           fill_reg;
    logic [CW-1:0]           fill_next;
    logic [AW-1:0]           i_reg;
    logic [AW-1:0]           i_next;
    logic [AW-1:0]           lim_reg;
    logic [AW-1:0]           lim_next;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           pos_next;
    logic                    hit_reg;
    logic                    hit_next;
    err_t                    err_reg;
    err_t                    err_next;
    logic [VAL_W-1:0]        rdv_reg;
    logic [VAL_W-1:0]        rdv_next;
    logic [VAL_W-1:0]        carry_reg;
    logic [VAL_W-1:0]        rd_data_reg;
    logic                    done_reg;
    logic                    found_reg;
    logic [POS_W-1:0]        position_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [VAL_W-1:0]        read_value_reg;
    err_t                    error_reg;

    logic [CW-1:0]           i_ext;
    logic [CW-1:0]           i_inc;
    logic [XW-1:0]           idx_x;
    logic [XW-1:0]           fill_x;
    logic [PW-1:0]           pos_wide;
    logic [NW-1:0]           cnt_wide;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic [VAL_W-1:0]        wr_data;
    logic                    carry_gt;

    assign i_ext    = CW'(i_reg);
    assign i_inc    = i_ext + CW'(1);
    assign idx_x    = XW'(index_reg);
    assign fill_x   = XW'(fill_reg);
    assign carry_gt = $signed(carry_reg) > $signed(rd_data_reg);

    assign stat.func         = func_reg;
    assign stat.match        = (rd_data_reg == value_reg);
    assign stat.hit          = hit_reg;
    assign stat.more_entries = (i_inc < fill_reg);
    assign stat.fill_empty   = (fill_reg == '0);
    assign stat.fill_gt1     = (fill_reg > CW'(1));
    assign stat.full         = (fill_reg == CAP_CNT);
    assign stat.idx_ok       = (idx_x < fill_x);
    assign stat.sort_more    = (i_inc < CW'(lim_reg));
    assign stat.lim_gt1      = (lim_reg > AW'(1));

    always_comb
    begin
        case (cmd.rd_sel)
            RD_AT_I:     rd_addr = i_reg;
            RD_AT_NEXT:  rd_addr = AW'(i_inc);
            RD_AT_INDEX: rd_addr = AW'(idx_x);
            default:     rd_addr = i_reg;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_reg;
        wr_data = carry_reg;
        if (cmd.wr_add)
        begin
            wr_en   = 1'b1;
            wr_addr = AW'(fill_reg);
            wr_data = value_reg;
        end
        else if (cmd.wr_shift)
        begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end
        else if (cmd.sort_step)
        begin
            wr_en   = 1'b1;
            wr_data = carry_gt ? rd_data_reg : carry_reg;
        end
        else if (cmd.sort_end)
        begin
            wr_en   = 1'b1;
            wr_addr = lim_reg;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            value_reg <= value;
            index_reg <= index;
        end
        if (cmd.ld_carry || (cmd.sort_step && !carry_gt))
        begin
            carry_reg <= rd_data_reg;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clr_fill)
        begin
            fill_next = '0;
        end
        else if (cmd.wr_add)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (cmd.dec_fill)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        pos_next = pos_reg;
        err_next = err_reg;
        rdv_next = rdv_reg;
        i_next   = i_reg;
        lim_next = lim_reg;
        if (cmd.load)
        begin
            hit_next = 1'b0;
            pos_next = '0;
            err_next = ERR_OK;
            rdv_next = '0;
            i_next   = '0;
        end
        if (cmd.set_hit)
        begin
            hit_next = 1'b1;
            pos_next = i_reg;
        end
        if (cmd.err_full)
        begin
            err_next = ERR_FULL;
        end
        if (cmd.err_range)
        begin
            err_next = ERR_RANGE;
        end
        if (cmd.take_read)
        begin
            rdv_next = rd_data_reg;
        end
        if (cmd.inc_i || cmd.sort_step)
        begin
            i_next = AW'(i_inc);
        end
        if (cmd.init_lim)
        begin
            i_next   = '0;
            lim_next = AW'(fill_reg - CW'(1));
        end
        if (cmd.sort_end)
        begin
            i_next   = '0;
            lim_next = lim_reg - AW'(1);
        end
    end

    assign pos_wide = PW'(pos_next);
    assign cnt_wide = NW'(fill_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            hit_reg        <= 1'b0;
            pos_reg        <= '0;
            err_reg        <= ERR_OK;
            rdv_reg        <= '0;
            i_reg          <= '0;
            lim_reg        <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            position_reg   <= '0;
            count_reg      <= '0;
            read_value_reg <= '0;
            error_reg      <= ERR_OK;
        end
        else
        begin
            fill_reg <= fill_next;
            hit_reg  <= hit_next;
            pos_reg  <= pos_next;
            err_reg  <= err_next;
            rdv_reg  <= rdv_next;
            i_reg    <= i_next;
            lim_reg  <= lim_next;
            done_reg <= cmd.finish;
            if (cmd.finish)
            begin
                found_reg      <= hit_next;
                position_reg   <= pos_wide[POS_W-1:0];
                count_reg      <= cnt_wide[CNT_W-1:0];
                read_value_reg <= rdv_next;
                error_reg      <= err_next;
            end
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign position   = position_reg;
    assign count      = count_reg;
    assign read_value = read_value_reg;
    assign error      = error_reg;

endmodule
`default_nettype wire

/* rtl/small_set_store_with_sort.sv */
// one request per start; the result strobe done ends each request: add/remove/find compare the
// stored entries in turn until a match (none on an empty set), a remove with a match then shifts
// the later entries down one place, and sort makes passes over the entries, each pass one shorter
// than the last, down to a pass over the first two; busy is high until the strobe, a new request
// may start in the done cycle
// rst_n clears the fill count and control state asynchronously; entries are not cleared
`default_nettype none
module small_set_store_with_sort
    import sss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [FUNC_W-1:0]       func,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic [IDX_W-1:0]        index,
    output logic                         busy,
    output logic                         done,
    output logic                         found,
    output logic [POS_W-1:0]             position,
    output logic [CNT_W-1:0]             count,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [ERR_W-1:0]             error
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    sss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (func),
        .value      (value),
        .index      (index),
        .cmd        (cmd),
        .stat       (stat),
        .done       (done),
        .found      (found),
        .position   (position),
        .count      (count),
        .read_value (read_value),
        .error      (error)
    );

endmodule
`default_nettype wire

/* rtl/sss_checker.sv */
`default_nettype none
module sss_checker
    import sss_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    done,
    input wire logic                    found,
    input wire logic [POS_W-1:0]        position,
    input wire logic signed [VAL_W-1:0] read_value,
    input wire logic [ERR_W-1:0]        error
);

    // accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // result appears as the block returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // one strobe per request
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for two cycles");

    // out of range read returns zero
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error == ERR_RANGE) |-> (read_value == '0 && !found))
        else $error("range error with data or found");

    // full error only when value absent
    a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error == ERR_FULL) |-> (!found && position == '0))
        else $error("full error with found value");

endmodule

bind small_set_store_with_sort sss_checker u_sss_checker (.*);
`default_nettype wire
